### rtl/core/tcpdt_pkg.sv
// Package for the TCP header decision-tree filter.
// Holds the field widths, the tree thresholds and the comparison result type.
// No dependencies.
package tcpdt_pkg;

    localparam int LEN_W   = 16;
    localparam int WORDS_W = 4;
    localparam int FLAG_W  = 8;
    localparam int WIN_W   = 16;
    localparam int ID_W    = 16;
    localparam int TOS_W   = 8;
    localparam int HB_W    = WORDS_W + 2;

    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 4;

    localparam logic [LEN_W-1:0] LEN_T41  = 16'd41;
    localparam logic [LEN_W-1:0] LEN_T42  = 16'd42;
    localparam logic [LEN_W-1:0] LEN_T46  = 16'd46;
    localparam logic [LEN_W-1:0] LEN_T65  = 16'd65;
    localparam logic [LEN_W-1:0] PAY_T19  = 16'd19;

    localparam logic [HB_W-1:0] HB_T22 = 6'd22;
    localparam logic [HB_W-1:0] HB_T38 = 6'd38;
    localparam logic [HB_W-1:0] HB_T42 = 6'd42;

    localparam logic [WIN_W-1:0] WIN_T1     = 16'd1;
    localparam logic [WIN_W-1:0] WIN_T507   = 16'd507;
    localparam logic [WIN_W-1:0] WIN_T512   = 16'd512;
    localparam logic [WIN_W-1:0] WIN_T521   = 16'd521;
    localparam logic [WIN_W-1:0] WIN_T933   = 16'd933;
    localparam logic [WIN_W-1:0] WIN_T1024  = 16'd1024;
    localparam logic [WIN_W-1:0] WIN_T1025  = 16'd1025;
    localparam logic [WIN_W-1:0] WIN_T1026  = 16'd1026;
    localparam logic [WIN_W-1:0] WIN_T1300  = 16'd1300;
    localparam logic [WIN_W-1:0] WIN_T15616 = 16'd15616;
    localparam logic [WIN_W-1:0] WIN_T15749 = 16'd15749;
    localparam logic [WIN_W-1:0] WIN_T16472 = 16'd16472;
    localparam logic [WIN_W-1:0] WIN_T16498 = 16'd16498;
    localparam logic [WIN_W-1:0] WIN_T21780 = 16'd21780;
    localparam logic [WIN_W-1:0] WIN_T28944 = 16'd28944;
    localparam logic [WIN_W-1:0] WIN_T29008 = 16'd29008;
    localparam logic [WIN_W-1:0] WIN_T46454 = 16'd46454;
    localparam logic [WIN_W-1:0] WIN_T64157 = 16'd64157;
    localparam logic [WIN_W-1:0] WIN_T64520 = 16'd64520;
    localparam logic [WIN_W-1:0] WIN_T65524 = 16'd65524;

    localparam logic [ID_W-1:0] ID_T2     = 16'd2;
    localparam logic [ID_W-1:0] ID_T11    = 16'd11;
    localparam logic [ID_W-1:0] ID_T60    = 16'd60;
    localparam logic [ID_W-1:0] ID_T26421 = 16'd26421;
    localparam logic [ID_W-1:0] ID_T38767 = 16'd38767;
    localparam logic [ID_W-1:0] ID_T38841 = 16'd38841;
    localparam logic [ID_W-1:0] ID_T41284 = 16'd41284;
    localparam logic [ID_W-1:0] ID_T41467 = 16'd41467;
    localparam logic [ID_W-1:0] ID_T51143 = 16'd51143;
    localparam logic [ID_W-1:0] ID_T51161 = 16'd51161;
    localparam logic [ID_W-1:0] ID_T58935 = 16'd58935;
    localparam logic [ID_W-1:0] ID_T58937 = 16'd58937;
    localparam logic [ID_W-1:0] ID_T60710 = 16'd60710;
    localparam logic [ID_W-1:0] ID_T60827 = 16'd60827;

    localparam logic [TOS_W-1:0] TOS_T1 = 8'd1;
    localparam logic [TOS_W-1:0] TOS_T4 = 8'd4;

    typedef struct packed {
        logic is_tcp;
        logic df;
        logic fin;
        logic syn;
        logic rst;
        logic ack;
        logic len_lt_41;
        logic len_lt_42;
        logic len_lt_46;
        logic len_lt_65;
        logic pay_lt_19;
        logic hb_lt_22;
        logic hb_lt_38;
        logic hb_lt_42;
        logic w_lt_1;
        logic w_lt_507;
        logic w_lt_512;
        logic w_lt_521;
        logic w_lt_933;
        logic w_lt_1024;
        logic w_lt_1025;
        logic w_lt_1026;
        logic w_lt_1300;
        logic w_lt_15616;
        logic w_lt_15749;
        logic w_lt_16472;
        logic w_lt_16498;
        logic w_lt_21780;
        logic w_lt_28944;
        logic w_lt_29008;
        logic w_lt_46454;
        logic w_lt_64157;
        logic w_lt_64520;
        logic w_lt_65524;
        logic id_lt_2;
        logic id_lt_11;
        logic id_lt_60;
        logic id_lt_26421;
        logic id_lt_38767;
        logic id_lt_38841;
        logic id_lt_41284;
        logic id_lt_41467;
        logic id_lt_51143;
        logic id_lt_51161;
        logic id_lt_58935;
        logic id_lt_58937;
        logic id_lt_60710;
        logic id_lt_60827;
        logic tos_lt_1;
        logic tos_lt_4;
    } cmp_t;

endpackage

### rtl/core/tcpdt_compare.sv
// Threshold comparators for the TCP header decision-tree filter.
// Derives header and payload lengths and compares the fields against each tree threshold once.
// Depends on tcpdt_pkg.
module tcpdt_compare (
    input  logic                           is_tcp,
    input  logic [tcpdt_pkg::LEN_W-1:0]    total_length,
    input  logic [tcpdt_pkg::WORDS_W-1:0]  ip_header_words,
    input  logic [tcpdt_pkg::WORDS_W-1:0]  tcp_header_words,
    input  logic                           dont_fragment,
    input  logic [tcpdt_pkg::FLAG_W-1:0]   tcp_flag_bits,
    input  logic [tcpdt_pkg::WIN_W-1:0]    window_size,
    input  logic [tcpdt_pkg::ID_W-1:0]     ip_ident,
    input  logic [tcpdt_pkg::TOS_W-1:0]    type_of_service,
    output tcpdt_pkg::cmp_t                cmp
);
    import tcpdt_pkg::*;

    logic [HB_W-1:0]  tcp_bytes;
    logic [HB_W-1:0]  ip_bytes;
    logic [HB_W:0]    hdr_bytes;
    logic [LEN_W-1:0] payload;

    assign tcp_bytes = {tcp_header_words, 2'b00};
    assign ip_bytes  = {ip_header_words, 2'b00};
    assign hdr_bytes = {1'b0, ip_bytes} + {1'b0, tcp_bytes};
    assign payload   = total_length - {{(LEN_W-HB_W-1){1'b0}}, hdr_bytes};

    always_comb
    begin
        cmp.is_tcp      = is_tcp;
        cmp.df          = dont_fragment;
        cmp.fin         = tcp_flag_bits[FLAG_FIN];
        cmp.syn         = tcp_flag_bits[FLAG_SYN];
        cmp.rst         = tcp_flag_bits[FLAG_RST];
        cmp.ack         = tcp_flag_bits[FLAG_ACK];
        cmp.len_lt_41   = total_length < LEN_T41;
        cmp.len_lt_42   = total_length < LEN_T42;
        cmp.len_lt_46   = total_length < LEN_T46;
        cmp.len_lt_65   = total_length < LEN_T65;
        cmp.pay_lt_19   = payload < PAY_T19;
        cmp.hb_lt_22    = tcp_bytes < HB_T22;
        cmp.hb_lt_38    = tcp_bytes < HB_T38;
        cmp.hb_lt_42    = tcp_bytes < HB_T42;
        cmp.w_lt_1      = window_size < WIN_T1;
        cmp.w_lt_507    = window_size < WIN_T507;
        cmp.w_lt_512    = window_size < WIN_T512;
        cmp.w_lt_521    = window_size < WIN_T521;
        cmp.w_lt_933    = window_size < WIN_T933;
        cmp.w_lt_1024   = window_size < WIN_T1024;
        cmp.w_lt_1025   = window_size < WIN_T1025;
        cmp.w_lt_1026   = window_size < WIN_T1026;
        cmp.w_lt_1300   = window_size < WIN_T1300;
        cmp.w_lt_15616  = window_size < WIN_T15616;
        cmp.w_lt_15749  = window_size < WIN_T15749;
        cmp.w_lt_16472  = window_size < WIN_T16472;
        cmp.w_lt_16498  = window_size < WIN_T16498;
        cmp.w_lt_21780  = window_size < WIN_T21780;
        cmp.w_lt_28944  = window_size < WIN_T28944;
        cmp.w_lt_29008  = window_size < WIN_T29008;
        cmp.w_lt_46454  = window_size < WIN_T46454;
        cmp.w_lt_64157  = window_size < WIN_T64157;
        cmp.w_lt_64520  = window_size < WIN_T64520;
        cmp.w_lt_65524  = window_size < WIN_T65524;
        cmp.id_lt_2     = ip_ident < ID_T2;
        cmp.id_lt_11    = ip_ident < ID_T11;
        cmp.id_lt_60    = ip_ident < ID_T60;
        cmp.id_lt_26421 = ip_ident < ID_T26421;
        cmp.id_lt_38767 = ip_ident < ID_T38767;
        cmp.id_lt_38841 = ip_ident < ID_T38841;
        cmp.id_lt_41284 = ip_ident < ID_T41284;
        cmp.id_lt_41467 = ip_ident < ID_T41467;
        cmp.id_lt_51143 = ip_ident < ID_T51143;
        cmp.id_lt_51161 = ip_ident < ID_T51161;
        cmp.id_lt_58935 = ip_ident < ID_T58935;
        cmp.id_lt_58937 = ip_ident < ID_T58937;
        cmp.id_lt_60710 = ip_ident < ID_T60710;
        cmp.id_lt_60827 = ip_ident < ID_T60827;
        cmp.tos_lt_1    = type_of_service < TOS_T1;
        cmp.tos_lt_4    = type_of_service < TOS_T4;
    end

endmodule

### rtl/core/tcpdt_tree.sv
// Decision tree of the TCP header filter.
// Turns the comparator outcomes into the drop decision.
// Depends on tcpdt_pkg.
module tcpdt_tree (
    input  tcpdt_pkg::cmp_t cmp,
    output logic            drop
);
    import tcpdt_pkg::*;

    logic tree_drop;

    always_comb
    begin
        tree_drop = 1'b0;
        if (!cmp.len_lt_65)
        begin
            tree_drop = 1'b0;
        end
        else if (cmp.fin)
        begin
            if (cmp.w_lt_512 || cmp.id_lt_2 || !cmp.w_lt_16498 || !cmp.tos_lt_4)
                tree_drop = 1'b0;
            else if (!cmp.ack)
                tree_drop = 1'b1;
            else if (cmp.w_lt_1024)
                tree_drop = 1'b0;
            else if (cmp.w_lt_1025)
                tree_drop = !cmp.df;
            else
                tree_drop = !cmp.w_lt_15616;
        end
        else if (!cmp.hb_lt_38)
        begin
            if (cmp.w_lt_15749 || !cmp.w_lt_64520 || cmp.id_lt_11)
                tree_drop = 1'b0;
            else if (cmp.w_lt_16472)
                tree_drop = !cmp.hb_lt_42;
            else
                tree_drop = !cmp.w_lt_64157;
        end
        else if (!cmp.df)
        begin
            if (!cmp.syn)
            begin
                if (!cmp.len_lt_41 || cmp.w_lt_507 || !cmp.w_lt_1300)
                    tree_drop = 1'b0;
                else if (cmp.w_lt_1025)
                    tree_drop = cmp.id_lt_58935 || !cmp.id_lt_58937;
                else
                    tree_drop = cmp.rst && cmp.tos_lt_4;
            end
            else if (cmp.w_lt_521)
            begin
                tree_drop = !cmp.w_lt_507;
            end
            else if (cmp.w_lt_65524)
            begin
                if (cmp.len_lt_42 || !cmp.w_lt_1026 || !cmp.tos_lt_4)
                    tree_drop = 1'b0;
                else
                    tree_drop = !cmp.w_lt_933;
            end
            else
            begin
                tree_drop = cmp.tos_lt_4 && cmp.hb_lt_22;
            end
        end
        else if (cmp.w_lt_1)
        begin
            if (cmp.id_lt_60)
                tree_drop = !cmp.ack && cmp.tos_lt_1;
            else if (cmp.id_lt_38767)
                tree_drop = 1'b0;
            else if (cmp.id_lt_38841)
                tree_drop = 1'b1;
            else if (cmp.id_lt_41467)
                tree_drop = !cmp.id_lt_41284;
            else if (cmp.id_lt_60710)
                tree_drop = 1'b0;
            else
                tree_drop = cmp.id_lt_60827;
        end
        else if (cmp.pay_lt_19)
        begin
            if (cmp.w_lt_28944)
                tree_drop = 1'b0;
            else if (cmp.w_lt_29008)
                tree_drop = !cmp.id_lt_26421;
            else if (!cmp.rst)
                tree_drop = !cmp.id_lt_51143 && cmp.id_lt_51161;
            else
                tree_drop = !cmp.len_lt_46;
        end
        else
        begin
            tree_drop = !cmp.w_lt_21780 && cmp.w_lt_46454;
        end
    end

    assign drop = cmp.is_tcp && tree_drop;

endmodule

### rtl/core/tcp_header_decision_tree_filter_core.sv
// Top level of the TCP header decision-tree filter.
// The header fields are registered on start; the decision is then registered into drop, together with done.
// Throughput: one header per cycle; busy is never raised and the receiver cannot stall.
// Reset clears the input and result valid flags; payload registers are not reset.
// Depends on tcpdt_pkg, tcpdt_compare and tcpdt_tree.
module tcp_header_decision_tree_filter_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           is_tcp,
    input  logic [tcpdt_pkg::LEN_W-1:0]    total_length,
    input  logic [tcpdt_pkg::WORDS_W-1:0]  ip_header_words,
    input  logic [tcpdt_pkg::WORDS_W-1:0]  tcp_header_words,
    input  logic                           dont_fragment,
    input  logic [tcpdt_pkg::FLAG_W-1:0]   tcp_flag_bits,
    input  logic [tcpdt_pkg::WIN_W-1:0]    window_size,
    input  logic [tcpdt_pkg::ID_W-1:0]     ip_ident,
    input  logic [tcpdt_pkg::TOS_W-1:0]    type_of_service,
    output logic                           done,
    output logic                           drop
);
    import tcpdt_pkg::*;

    logic               in_valid_reg;
    logic               is_tcp_reg;
    logic [LEN_W-1:0]   total_length_reg;
    logic [WORDS_W-1:0] ip_header_words_reg;
    logic [WORDS_W-1:0] tcp_header_words_reg;
    logic               dont_fragment_reg;
    logic [FLAG_W-1:0]  tcp_flag_bits_reg;
    logic [WIN_W-1:0]   window_size_reg;
    logic [ID_W-1:0]    ip_ident_reg;
    logic [TOS_W-1:0]   type_of_service_reg;

    logic               done_reg;
    logic               drop_reg;
    logic               drop_next;
    cmp_t               cmp;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            is_tcp_reg           <= is_tcp;
            total_length_reg     <= total_length;
            ip_header_words_reg  <= ip_header_words;
            tcp_header_words_reg <= tcp_header_words;
            dont_fragment_reg    <= dont_fragment;
            tcp_flag_bits_reg    <= tcp_flag_bits;
            window_size_reg      <= window_size;
            ip_ident_reg         <= ip_ident;
            type_of_service_reg  <= type_of_service;
        end
        if (in_valid_reg)
        begin
            drop_reg <= drop_next;
        end
    end

    tcpdt_compare u_compare (
        .is_tcp           (is_tcp_reg),
        .total_length     (total_length_reg),
        .ip_header_words  (ip_header_words_reg),
        .tcp_header_words (tcp_header_words_reg),
        .dont_fragment    (dont_fragment_reg),
        .tcp_flag_bits    (tcp_flag_bits_reg),
        .window_size      (window_size_reg),
        .ip_ident         (ip_ident_reg),
        .type_of_service  (type_of_service_reg),
        .cmp              (cmp)
    );

    tcpdt_tree u_tree (
        .cmp  (cmp),
        .drop (drop_next)
    );

    assign done = done_reg;
    assign drop = drop_reg;

endmodule
